FILE: sv/lpbd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed block deframer package
// Shared constants and the output beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbd_pkg;

  // Block header layout.
  localparam int HDR_BYTES = 8;
  localparam int LEN_FIRST = 4;

  // Default clamp for the total block length.
  localparam int MAX_MSG_DEFAULT = 4096;

  // Result field widths.
  localparam int DATA_W  = 8;
  localparam int INDEX_W = 12;
  localparam int BLEN_W  = 13;

  // Stream widths: tdata holds data_byte, byte_index, block_length padded to
  // whole bytes; tuser holds block_start then length_valid.
  localparam int TDATA_FIELDS_W = DATA_W + INDEX_W + BLEN_W;
  localparam int TDATA_W        = ((TDATA_FIELDS_W + 7) / 8) * 8;
  localparam int TUSER_W        = 2;

  // Bit positions inside tdata and tuser.
  localparam int TDATA_INDEX_LSB = DATA_W;
  localparam int TDATA_BLEN_LSB  = DATA_W + INDEX_W;
  localparam int TUSER_START     = 0;
  localparam int TUSER_LVALID    = 1;

  // One output beat as it sits in the output buffer.
  typedef struct packed {
    logic               last;
    logic [TUSER_W-1:0] user;
    logic [TDATA_W-1:0] data;
  } beat_t;

endpackage

`default_nettype wire

FILE: sv/lpbd_skid.sv
// ----------------------------------------------------------------------------
// Two-entry output buffer
// Holds a result register and a skid register so the producer may hand over
// a new request while the consumer stalls on the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbd_skid #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_payload
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      // The result register is free this cycle: drain the skid first.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_payload <= skid_data;
      end else begin
        out_payload <= in_data;
      end
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/length_prefixed_block_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed block deframer
// Splits a received byte stream into blocks framed by an 8-byte header.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one registered result, and one byte
// is taken every cycle while the output side keeps up. The per-byte work is a
// block counter, a 32-bit length add and clamp on header byte 7, and a compare
// of the next index against the block length; a two-entry output buffer lets
// one more byte in while a result is stalled, after which s_tready drops.
// Header bytes 4 to 7 carry a big-endian length L, the block is L + 8 bytes
// long, and totals above MAX_MSG are clamped to MAX_MSG. A block ends on the
// byte whose index plus one reaches that total.
`default_nettype none

module length_prefixed_block_deframer
  import lpbd_pkg::*;
#(
  parameter int MAX_MSG = MAX_MSG_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,   // [7:0] data_byte, [19:8] byte_index,
                                             // [32:20] block_length, rest zero
  output logic                    m_tlast,   // block_end
  output logic [TUSER_W-1:0]      m_tuser    // [0] block_start, [1] length_valid
);

  localparam int CW   = $clog2(MAX_MSG);
  localparam int LW   = $clog2(MAX_MSG + 1);
  localparam int IW   = CW + 1;
  localparam int ACCW = 32 - DATA_W;

  logic [CW-1:0]   byte_count;
  logic [ACCW-1:0] length_accum;
  logic [LW-1:0]   expected_length;

  logic            accept;
  logic            hdr_done;
  logic            in_len;
  logic            at_len_end;
  logic [31:0]     length_full;
  logic [32:0]     total;
  logic [LW-1:0]   clamped;
  logic [LW-1:0]   length_eff;
  logic            valid_len;
  logic            last_byte;
  logic [IW-1:0]   index_plus;
  logic            in_beat_ready;
  beat_t           in_beat;
  beat_t           out_beat;

  assign accept = s_tvalid && in_beat_ready;
  assign s_tready = in_beat_ready;

  assign hdr_done   = (expected_length != '0);
  assign in_len     = !hdr_done && (byte_count >= CW'(LEN_FIRST)) &&
                      (byte_count < CW'(HDR_BYTES));
  assign at_len_end = !hdr_done && (byte_count == CW'(HDR_BYTES - 1));

  // Header byte 7 completes the length; the total is formed without wrap.
  assign length_full = {length_accum, s_tdata};
  assign total       = {1'b0, length_full} + 33'(HDR_BYTES);
  assign clamped     = (total > 33'(MAX_MSG)) ? LW'(MAX_MSG) : total[LW-1:0];
  assign length_eff  = at_len_end ? clamped : expected_length;
  assign valid_len   = (length_eff != '0);

  assign index_plus = IW'(byte_count) + IW'(1);
  assign last_byte  = valid_len && (index_plus >= IW'(length_eff));

  always_comb begin
    in_beat                                           = '0;
    in_beat.data[DATA_W-1:0]                          = s_tdata;
    in_beat.data[TDATA_INDEX_LSB +: INDEX_W]          = INDEX_W'(byte_count);
    in_beat.data[TDATA_BLEN_LSB +: BLEN_W]            = BLEN_W'(length_eff);
    in_beat.user[TUSER_START]                         = (byte_count == '0);
    in_beat.user[TUSER_LVALID]                        = valid_len;
    in_beat.last                                      = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      length_accum    <= '0;
      expected_length <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count      <= '0;
        length_accum    <= '0;
        expected_length <= '0;
      end else begin
        byte_count      <= index_plus[CW-1:0];
        expected_length <= length_eff;
        if (in_len) begin
          length_accum <= length_full[ACCW-1:0];
        end
      end
    end
  end

  lpbd_skid #(
    .WIDTH ($bits(beat_t))
  ) u_skid (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (in_beat_ready),
    .in_data     (in_beat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_payload (out_beat)
  );

  assign m_tdata = out_beat.data;
  assign m_tuser = out_beat.user;
  assign m_tlast = out_beat.last;

endmodule

`default_nettype wire

FILE: sv/lpbd_checker.sv
// ----------------------------------------------------------------------------
// Length-prefixed block deframer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbd_checker
  import lpbd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic               m_tlast,
  input wire logic [TUSER_W-1:0] m_tuser
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
    $stable(m_tuser))
    else $error("stalled result changed");

  // The input side only backs off after the output side stalled.
  a_backoff: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output stall");

  // A block can only end once its length is known.
  a_end_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[TUSER_LVALID])
    else $error("block end before header complete");

  // Without a known length the reported length is zero.
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[TUSER_LVALID] |->
    m_tdata[TDATA_BLEN_LSB +: BLEN_W] == '0)
    else $error("block length reported before header complete");

  // The first byte of a block sits at index zero.
  a_start_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[TUSER_START] |-> m_tdata[TDATA_INDEX_LSB +: INDEX_W] == '0)
    else $error("block start at nonzero index");

endmodule

bind length_prefixed_block_deframer lpbd_checker u_lpbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Length-prefixed block deframer testbench
// Streams framed byte blocks into the deframer and checks every output beat
// against a cycle-free model of the block counter and the length clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import lpbd_pkg::*;

  localparam int BLOCK_MAX   = MAX_MSG_DEFAULT;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 12;
  localparam int PAD_LSB     = TDATA_BLEN_LSB + BLEN_W;

  typedef struct {
    logic [DATA_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               is_first;
    logic               block_end;
    logic               length_valid;
    logic [BLEN_W-1:0]  block_length;
  } deframed_byte_t;

  // Tracks the block position of the byte stream and holds the beats that
  // are still owed by the deframer, oldest first.
  class deframe_scoreboard;
    logic [INDEX_W-1:0] byte_count;
    logic [31:0]        length_accum;
    logic [BLEN_W-1:0]  expected_length;
    deframed_byte_t     expected_beats[$];
    int unsigned        mismatches;

    function new();
      byte_count      = '0;
      length_accum    = '0;
      expected_length = '0;
      mismatches      = 0;
    endfunction

    function deframed_byte_t deframe_byte(logic [DATA_W-1:0] rx);
      deframed_byte_t r;
      logic [32:0]    total;
      int unsigned    idx;
      idx = int'(byte_count);
      r.data_byte   = rx;
      r.byte_index  = byte_count;
      r.is_first    = (idx == 0);
      if (expected_length == 0 && idx >= LEN_FIRST && idx < HDR_BYTES) begin
        length_accum = {length_accum[23:0], rx};
      end
      // The total is formed one bit wider so that lengths near 2^32 cannot wrap.
      if (expected_length == 0 && idx == HDR_BYTES - 1) begin
        total = {1'b0, length_accum} + 33'(HDR_BYTES);
        if (total > 33'(BLOCK_MAX)) begin
          total = 33'(BLOCK_MAX);
        end
        expected_length = total[BLEN_W-1:0];
      end
      r.length_valid = (expected_length != 0);
      r.block_length = expected_length;
      r.block_end    = r.length_valid && (idx + 1 >= int'(expected_length));
      if (r.block_end) begin
        byte_count      = '0;
        length_accum    = '0;
        expected_length = '0;
      end else begin
        byte_count = byte_count + 1'b1;
      end
      return r;
    endfunction

    function void note_rx_byte(logic [DATA_W-1:0] rx);
      expected_beats.push_back(deframe_byte(rx));
    endfunction

    function void check_beat(logic [TDATA_W-1:0] tdata, logic tlast,
                             logic [TUSER_W-1:0] tuser);
      deframed_byte_t e;
      bit             bad;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result tdata=%h tlast=%b tuser=%b",
                   tdata, tlast, tuser);
        end
        return;
      end
      e = expected_beats.pop_front();
      bad = (tdata[DATA_W-1:0] !== e.data_byte)
         || (tdata[TDATA_INDEX_LSB +: INDEX_W] !== e.byte_index)
         || (tdata[TDATA_BLEN_LSB +: BLEN_W] !== e.block_length)
         || (tdata[TDATA_W-1:PAD_LSB] !== '0)
         || (tlast !== e.block_end)
         || (tuser[TUSER_START] !== e.is_first)
         || (tuser[TUSER_LVALID] !== e.length_valid);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: expected byte=%h idx=%0d len=%0d start=%b end=%b lv=%b",
                   e.data_byte, e.byte_index, e.block_length, e.is_first,
                   e.block_end, e.length_valid);
          $display("       got byte=%h idx=%0d len=%0d pad=%h start=%b end=%b lv=%b",
                   tdata[DATA_W-1:0], tdata[TDATA_INDEX_LSB +: INDEX_W],
                   tdata[TDATA_BLEN_LSB +: BLEN_W], tdata[TDATA_W-1:PAD_LSB],
                   tuser[TUSER_START], tlast, tuser[TUSER_LVALID]);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [DATA_W-1:0]  s_tdata;   // [7:0] rx_byte
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;   // [7:0] data_byte, [19:8] byte_index,
                                 // [32:20] block_length, rest zero
  logic               m_tlast;   // block_end
  logic [TUSER_W-1:0] m_tuser;   // [0] block_start, [1] length_valid

  deframe_scoreboard sb = new();

  bit          no_idle      = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;

  length_prefixed_block_deframer #(
    .MAX_MSG(BLOCK_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Both handshakes are sampled here, along with the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_rx_byte(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        sb.check_beat(m_tdata, m_tlast, m_tuser);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: no request accepted for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [DATA_W-1:0] b);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // Random header filler, the big-endian length, then the given payload count.
  task automatic send_header_and_payload(input logic [31:0] len,
                                         input int unsigned payload);
    int unsigned i;
    for (i = 0; i < LEN_FIRST; i++) begin
      send_byte(DATA_W'($urandom_range(0, 255)));
    end
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (i = 0; i < payload; i++) begin
      send_byte(DATA_W'($urandom_range(0, 255)));
    end
  endtask

  // A complete block whose payload follows the clamped total.
  task automatic send_block(input logic [31:0] len);
    logic [32:0] total;
    int unsigned payload;
    total = {1'b0, len} + 33'(HDR_BYTES);
    if (total > 33'(BLOCK_MAX)) begin
      total = 33'(BLOCK_MAX);
    end
    payload = int'(total[BLEN_W-1:0]) - HDR_BYTES;
    send_header_and_payload(len, payload);
  endtask

  task automatic run_random_blocks(input int unsigned n);
    int unsigned first;
    int unsigned pick;
    logic [31:0] len;
    first = bytes_sent;
    while (bytes_sent - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        len = 0;
      end else if (pick < 80) begin
        len = $urandom_range(1, 24);
      end else if (pick < 95) begin
        len = $urandom_range(25, 120);
      end else begin
        len = $urandom_range(121, 600);
      end
      send_block(len);
    end
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned i;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Header-only block: a zero length ends the block on the last header byte.
    for (i = 0; i < LEN_FIRST; i++) begin
      send_byte(8'hFF);
    end
    for (i = 0; i < LEN_FIRST; i++) begin
      send_byte(8'h00);
    end
    // Two payload bytes at the value extremes after a header of length two.
    for (i = 0; i < HDR_BYTES - 1; i++) begin
      send_byte(8'h00);
    end
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(8'h00);

    run_random_blocks(260);
    // The receiver stalls while bytes keep coming, so the input must back up.
    hold_request = 1'b1;
    run_random_blocks(220);
    wait_for_drain();

    // A long stretch with no idling on either side.
    no_idle = 1'b1;
    run_random_blocks(200);
    no_idle = 1'b0;

    run_random_blocks(220);

    // A length whose total overflows 32 bits must clamp rather than wrap;
    // the block is left open at the end of the run.
    send_header_and_payload(32'hFFFF_FFF8, 40);
    wait_for_drain();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.pending() != 0) begin
        $display("ERROR: %0d expected results never arrived", sb.pending());
      end
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/lpbd_pkg.sv
sv/lpbd_skid.sv
sv/length_prefixed_block_deframer.sv
sv/lpbd_checker.sv
sim/testbench.sv
